// ===== rtl/ordq_pkg.sv =====
// ----------------------------------------------------------------------------
// ordq_pkg
// Shared types and constants of the output-restricted deque.
// ----------------------------------------------------------------------------
`default_nettype none

package ordq_pkg;

  // Word and field widths of a request and its result.
  localparam int WORD_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // Default number of slots in the ring.
  localparam int DEFAULT_DEPTH = 16;

  // Word returned by a pop from an empty queue.
  localparam logic signed [WORD_W-1:0] UNDERFLOW_WORD = -32'sd999;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2
  } ordq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } ordq_status_t;

endpackage : ordq_pkg

`default_nettype wire

// ===== rtl/output_restricted_deque_core.sv =====
// ----------------------------------------------------------------------------
// output_restricted_deque_core
// Output-restricted deque of signed 32-bit words kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------
//   in_      in_valid / in_stall  in_operation, in_data_in
//   out_     out_valid/out_stall  out_data_out, out_status, out_fill_count
//
// A push, a failed pop, or an unused operation code has its result loaded into
// the output register at the edge that accepts it. A pop that finds a word
// passes through the registered read port of the slot RAM before its word is
// loaded into the output register; the input stalls during the read.
// A new request is accepted while the previous result is being taken.
// Reset clears the pointers, the occupancy, the pending-read flag and the output
// valid flag; the slot RAM is not cleared, since only written slots are ever popped.
// ----------------------------------------------------------------------------
`default_nettype none

module output_restricted_deque_core #(
  parameter int DEPTH = ordq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Request channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ordq_pkg::OP_W-1:0]           in_operation,
  input  wire logic signed [ordq_pkg::WORD_W-1:0]  in_data_in,
  // Result channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ordq_pkg::WORD_W-1:0]       out_data_out,
  output logic [ordq_pkg::STATUS_W-1:0]            out_status,
  output logic [ordq_pkg::FILL_W-1:0]              out_fill_count
);

  import ordq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  // Ring pointers and occupancy. The head points at the front word; the tail
  // points at the free slot behind the rear word.
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r,  occ_nxt;

  // Set while a pop waits for its word from the RAM.
  logic             rd_pend_r, rd_pend_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_data_r,  out_data_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [FILL_W-1:0]        out_fill_r,  out_fill_nxt;

  // RAM ports.
  logic              ram_we;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_waddr;
  logic [PTR_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // Result of the request accepted in this cycle.
  logic                     load_out;
  logic signed [WORD_W-1:0] res_data;
  ordq_status_t             res_status;

  logic                     accept;
  logic                     out_take;
  logic                     is_full;
  logic                     is_empty;
  logic [OCC_W+FILL_W-1:0]  occ_ext;

  ordq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The input waits while a pop read is in flight, or while a finished
  // result is held by the receiver. A result being taken this cycle frees
  // the output register for the next request.
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = rd_pend_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_full  = (occ_r == OCC_W'(DEPTH));
  assign is_empty = (occ_r == '0);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    rd_pend_nxt = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_r;
    ram_raddr   = head_r;
    ram_wdata   = in_data_in;
    load_out    = 1'b0;
    res_data    = '0;
    res_status  = ST_OK;

    if (accept) begin
      load_out = 1'b1;
      unique case (in_operation)
        OP_PUSH_REAR: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
            occ_nxt   = occ_r + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            head_nxt  = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;
            ram_we    = 1'b1;
            ram_waddr = head_nxt;
            occ_nxt   = occ_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            res_data   = UNDERFLOW_WORD;
            res_status = ST_EMPTY;
          end else begin
            // The word arrives from the registered RAM read port in the next cycle.
            load_out    = 1'b0;
            rd_pend_nxt = 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = head_r;
            occ_nxt     = occ_r - 1'b1;
            if (occ_r == OCC_W'(1)) begin
              // The last word leaves: the ring restarts at slot zero.
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
            end
          end
        end
        default: begin
          // An unused operation code changes nothing and reports ok.
        end
      endcase
    end
  end

  assign occ_ext = {{FILL_W{1'b0}}, occ_nxt};

  // Output register next values. Status and fill count are known at the
  // accepting edge for every request; a pop's word is loaded at the edge after it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_status_nxt = res_status;
      out_fill_nxt   = occ_ext[FILL_W-1:0];
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

  // A pop read only starts once the output register is free, so its word
  // never overwrites a result still waiting to be taken.
  a_read_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("pop read in flight while output register holds a result");

  // No request may enter while a pop read is in flight.
  a_read_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> in_stall)
    else $error("request accepted during a pop read");

  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy exceeds ring depth");

  // An empty ring always sits at slot zero.
  a_empty_reset_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty ring with nonzero pointers");

endmodule : output_restricted_deque_core

`default_nettype wire

// ===== rtl/ordq_ram.sv =====
// ----------------------------------------------------------------------------
// ordq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ordq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ordq_ram

`default_nettype wire

// ===== tb/output_restricted_deque_core_test.sv =====
// ----------------------------------------------------------------------------
// output_restricted_deque_core_test
// Self-checking bench for the output-restricted deque: directed corner cases
// (underflow, overflow at both ends, draining to empty, the unused operation
// code) followed by random push/pop phases with a changing push/pop balance.
// Every result is compared field by field against an in-bench ring model.
// ----------------------------------------------------------------------------
`default_nettype none

module output_restricted_deque_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ordq_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One expected result of the deque.
  typedef struct {
    logic signed [WORD_W-1:0] data_out;
    ordq_status_t             status;
    logic [FILL_W-1:0]        fill;
  } deque_result_t;

  // The scoreboard keeps its own ring of words with front and rear indexes and
  // a word count. Every accepted request is applied to that ring right away and
  // the result it must produce is queued, since the block answers in order.
  class deque_scoreboard;
    logic signed [WORD_W-1:0] ring [DEPTH];
    int unsigned              front_idx;
    int unsigned              rear_idx;
    int unsigned              stored;
    deque_result_t            awaited [$];
    int unsigned              errors;

    function new();
      front_idx = 0;
      rear_idx  = 0;
      stored    = 0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_request(input logic [OP_W-1:0] op,
                               input logic signed [WORD_W-1:0] word);
      deque_result_t r;
      r.data_out = '0;
      r.status   = ST_OK;
      case (op)
        OP_PUSH_REAR, OP_PUSH_FRONT: begin
          if (stored >= DEPTH) begin
            r.status = ST_FULL;
          end else if (op == OP_PUSH_REAR) begin
            ring[rear_idx] = word;
            rear_idx = (rear_idx + 1) % DEPTH;
            stored++;
          end else begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            ring[front_idx] = word;
            stored++;
          end
        end
        OP_POP_FRONT: begin
          if (stored == 0) begin
            r.data_out = UNDERFLOW_WORD;
            r.status   = ST_EMPTY;
          end else begin
            r.data_out = ring[front_idx];
            front_idx = (front_idx + 1) % DEPTH;
            stored--;
            // An emptied queue starts over from slot zero.
            if (stored == 0) begin
              front_idx = 0;
              rear_idx  = 0;
            end
          end
        end
        default: begin
        end
      endcase
      r.fill = FILL_W'(stored);
      awaited.push_back(r);
    endfunction

    function void check_result(input logic signed [WORD_W-1:0] data,
                               input logic [STATUS_W-1:0] status,
                               input logic [FILL_W-1:0] fill);
      deque_result_t r;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: data_out %0d status %0d fill_count %0d",
               data, status, fill);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (data !== r.data_out) begin
        $error("data_out: expected %0d, actual %0d", r.data_out, data);
        errors++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (fill !== r.fill) begin
        $error("fill_count: expected %0d, actual %0d", r.fill, fill);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_operation;
  logic signed [WORD_W-1:0]   in_data_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [WORD_W-1:0]   out_data_out;
  logic [STATUS_W-1:0]        out_status;
  logic [FILL_W-1:0]          out_fill_count;

  deque_scoreboard board = new();

  // When set, neither side inserts idle cycles, so back-to-back traffic is seen.
  bit steady = 1'b0;

  output_restricted_deque_core #(.DEPTH(DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Words are mostly random, with the extremes of the signed range mixed in so
  // that the sign bit and all-ones patterns pass through the store often.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one request and returns once the block has accepted it. The valid
  // flag is only lowered when an idle gap is drawn, so a request that follows
  // without a gap keeps valid high across the boundary.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [WORD_W-1:0] word);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_in   <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, word);
  endtask

  // Holds the request channel idle until every outstanding result has arrived.
  // The loop waits on a clock edge before it tests the count, so the following
  // request raises valid in a later time step than the one that lowered it.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // One random phase. push_pct sets how often a request is a push, which steers
  // the queue toward full or toward empty; a small share of requests use the
  // unused operation code.
  task automatic random_phase(input int count, input int unsigned push_pct);
    int unsigned roll;
    logic [OP_W-1:0] op;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        op = OP_UNUSED;
      end else if (roll < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = OP_POP_FRONT;
      end
      send_request(op, pick_word());
    end
  endtask

  // Result side: for every result a random stall is drawn (none in steady mode),
  // then the stall stays low until a result has been taken.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  // Every result the block hands over is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data_out, out_status, out_fill_count);
    end
  end

  initial begin : stimulus
    int unsigned mix [5] = '{25, 50, 75, 90, 10};
    in_valid     <= 1'b0;
    in_operation <= OP_PUSH_REAR;
    in_data_in   <= '0;
    rst_n        <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Underflow and the unused code on a freshly reset queue.
    send_request(OP_POP_FRONT, 32'sh7FFF_FFFF);
    send_request(OP_UNUSED, 32'sh8000_0000);
    // One word at each end, then both popped; the second pop empties the queue
    // and the pop after it must underflow again.
    send_request(OP_PUSH_REAR, 32'sh7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'sh8000_0000);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_FRONT, '1);
    send_request(OP_POP_FRONT, '0);
    // Fill to capacity from both ends, then try to overflow at each end.
    for (int k = 0; k < DEPTH; k++) begin
      send_request((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word());
    end
    send_request(OP_PUSH_REAR, '1);
    send_request(OP_PUSH_FRONT, 32'sh8000_0000);
    send_request(OP_UNUSED, '1);

    // Random phases. Every fourth one runs without idle cycles on either side,
    // and twice the sender waits for the queue of results to run dry.
    for (int p = 0; p < 16; p++) begin
      steady = (p % 4 == 3);
      random_phase(100, mix[p % 5]);
      if (p == 5 || p == 11) begin
        drain_results();
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("output_restricted_deque_core: match");
    end else begin
      $display("output_restricted_deque_core: mismatch");
    end
    $finish;
  end

  // Safety net in case the handshake locks up.
  initial begin : watchdog
    #3_000_000;
    $display("output_restricted_deque_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ordq_pkg.sv
rtl/ordq_ram.sv
rtl/output_restricted_deque_core.sv
tb/output_restricted_deque_core_test.sv
